FILE: hw/rtl/flf_pkg.sv
// shared types and constants of the fixed string line filter
package flf_pkg;

	// line fill counter width, covers every line store size up to 63 bytes
	localparam int FILL_W = 6;

	// newline byte that splits lines and closes emitted ones
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int PAT_LEN_W  = 5;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

	// bytes held by the two pattern registers
	localparam int PAT_BYTES = 16;

	// one closed, matching line waiting to be sent
	typedef struct packed {
		logic              bank;
		logic [FILL_W-1:0] fill;
		logic              trunc;
	} line_cmd_t;

	// front to queue and queue to back
	typedef struct packed {
		logic      valid;
		line_cmd_t cmd;
	} line_req_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SEND,
		BK_NEWLINE
	} back_state_t;

endpackage

FILE: hw/rtl/fixed_string_line_filter.sv
// top level of the fixed string line filter
//
// Text bytes enter on the s_ stream, one per request, s_tlast marking the final
// byte of the input. Lines end at newline bytes; each line that contains the
// pattern set through the cfg_ port (pattern_length 0 matches all lines) is
// sent on the m_ stream byte by byte, followed by a newline request with
// m_tlast high. m_tuser is high on every request of a line longer than the
// line store; such a line is sent cut to MAX_LINE bytes.
// Intake takes one byte per cycle while s_tready is high. The line store has
// two banks: while the back end replays one closed line the front keeps
// filling the other, and s_tready drops only while both banks hold lines not
// yet sent. Each stored byte goes out as a line store read, then the request,
// and a newline request with m_tlast high follows the last byte; a matching
// line passes through the command queue before its first line store read.
// A stalled receiver holds the current request and, once both banks are
// full, stalls intake. Reset clears the pattern registers and all line and
// queue state; the line store needs no clearing. Configuration is to be
// written by the user only while no line is in flight; the block does not
// enforce this. An open line keeps a match already seen.
module fixed_string_line_filter
	import flf_pkg::*;
#(
	parameter int MAX_LINE    = 63,
	parameter int PATTERN_MAX = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // text_byte
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // out_byte
	output logic                  m_tlast,
	output logic                  m_tuser    // line_truncated
);

	localparam int DEPTH = 2 * MAX_LINE;
	localparam int AW    = $clog2(DEPTH);

	line_req_t     push;
	line_req_t     head;
	logic          q_full;
	logic          pop;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	// intake and matching
	flf_front #(
		.MAX_LINE    (MAX_LINE),
		.PATTERN_MAX (PATTERN_MAX),
		.AW          (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// two bank line store
	flf_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// closed lines waiting for output
	flf_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	// line replay
	flf_back #(
		.MAX_LINE (MAX_LINE),
		.AW       (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: hw/rtl/flf_ram.sv
// generic simple dual port ram with registered read
module flf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/flf_front.sv
// front end: config registers, byte intake, pattern window and line close
module flf_front
	import flf_pkg::*;
#(
	parameter int MAX_LINE    = 63,
	parameter int PATTERN_MAX = 16,
	parameter int AW          = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tlast,
	input  logic                  q_full,
	output line_req_t             push,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output logic [7:0]            wr_data
);

	localparam int PW = $clog2(PATTERN_MAX + 1);

	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [PAT_LEN_W-1:0]  pat_len_q;
	logic [7:0]            win_q [PATTERN_MAX];
	logic [PW-1:0]         wfill_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  ovf_q;
	logic                  matched_q;
	logic                  bank_q;

	logic [7:0]        pat [PAT_BYTES];
	logic [7:0]        win_n [PATTERN_MAX];
	logic [PW-1:0]     wfill_n;
	logic [PW-1:0]     plen;
	logic              accept;
	logic              is_nl;
	logic              add;
	logic              has_room;
	logic              hit;
	logic              close;
	logic              emit;
	logic [FILL_W-1:0] fill_n;
	logic              ovf_n;
	logic              matched_n;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_PAT_LOW) begin
				pat_lo_q <= cfg_data;
			end
			if (cfg_index == REG_PAT_HIGH) begin
				pat_hi_q <= cfg_data;
			end
			if (cfg_index == REG_PAT_LEN) begin
				pat_len_q <= cfg_data[PAT_LEN_W-1:0];
			end
		end
	end

	// pattern bytes and active length, saturated to the window size
	always_comb begin
		for (int i = 0; i < PAT_BYTES / 2; i++) begin
			pat[i]                 = pat_lo_q[8*i +: 8];
			pat[i + PAT_BYTES / 2] = pat_hi_q[8*i +: 8];
		end
		if (pat_len_q > PAT_LEN_W'(PATTERN_MAX)) begin
			plen = PW'(PATTERN_MAX);
		end else begin
			plen = PW'(pat_len_q);
		end
	end

	// intake handshake and byte class
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_nl    = (s_tdata == NEWLINE_BYTE);
	assign add      = accept && !is_nl;
	assign has_room = (fill_q < FILL_W'(MAX_LINE));

	// window after shifting in the current byte, newest at the top
	always_comb begin
		for (int j = 0; j < PATTERN_MAX - 1; j++) begin
			win_n[j] = win_q[j + 1];
		end
		win_n[PATTERN_MAX - 1] = s_tdata;
		if (wfill_q < PW'(PATTERN_MAX)) begin
			wfill_n = wfill_q + 1'b1;
		end else begin
			wfill_n = wfill_q;
		end
	end

	// compare the newest plen window bytes with the pattern
	always_comb begin
		logic ok;
		ok = 1'b1;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			if (j >= PATTERN_MAX - int'(plen)) begin
				if (win_n[j] != pat[4'(j + int'(plen) - PATTERN_MAX)]) begin
					ok = 1'b0;
				end
			end
		end
		hit = ok && (plen != '0) && (wfill_n >= plen);
	end

	// line state after this byte
	always_comb begin
		fill_n    = (add && has_room) ? fill_q + 1'b1 : fill_q;
		ovf_n     = ovf_q | (add && !has_room);
		matched_n = matched_q | (add && hit);
		close     = accept && (is_nl || s_tlast);
		emit      = close && (matched_n || (plen == '0));
	end

	// request to the back end for a matching line
	always_comb begin
		push.valid     = emit;
		push.cmd.bank  = bank_q;
		push.cmd.fill  = fill_n;
		push.cmd.trunc = ovf_n;
	end

	// line store write into the open bank
	assign wr_en   = add && has_room;
	assign wr_addr = bank_q ? AW'(MAX_LINE) + AW'(fill_q) : AW'(fill_q);
	assign wr_data = s_tdata;

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wfill_q   <= '0;
			fill_q    <= '0;
			ovf_q     <= 1'b0;
			matched_q <= 1'b0;
			bank_q    <= 1'b0;
		end else if (accept) begin
			if (close) begin
				wfill_q   <= '0;
				fill_q    <= '0;
				ovf_q     <= 1'b0;
				matched_q <= 1'b0;
				bank_q    <= bank_q ^ emit;
			end else begin
				wfill_q   <= wfill_n;
				fill_q    <= fill_n;
				ovf_q     <= ovf_n;
				matched_q <= matched_n;
			end
		end
	end

	// match window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < PATTERN_MAX; j++) begin
				win_q[j] <= '0;
			end
		end else if (add) begin
			for (int j = 0; j < PATTERN_MAX; j++) begin
				win_q[j] <= win_n[j];
			end
		end
	end

endmodule

FILE: hw/rtl/flf_cmd_queue.sv
// two entry queue of closed lines, one per line store bank
module flf_cmd_queue
	import flf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  line_req_t push,
	input  logic      pop,
	output logic      full,
	output line_req_t head
);

	line_cmd_t   slot_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = slot_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wptr_q] <= push.cmd;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/flf_back.sv
// back end: replays a matching line from the line store, then its newline
module flf_back
	import flf_pkg::*;
#(
	parameter int MAX_LINE = 63,
	parameter int AW       = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  line_req_t     head,
	output logic          pop,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast,
	output logic          m_tuser
);

	back_state_t       state_q;
	back_state_t       state_n;
	logic [FILL_W-1:0] idx_q;
	logic              last_byte;

	assign last_byte = (FILL_W'(idx_q + 1'b1) == head.cmd.fill);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					state_n = (head.cmd.fill == '0) ? BK_NEWLINE : BK_READ;
				end
			end
			BK_READ: begin
				state_n = BK_SEND;
			end
			BK_SEND: begin
				if (m_tready) begin
					state_n = last_byte ? BK_NEWLINE : BK_READ;
				end
			end
			BK_NEWLINE: begin
				if (m_tready) begin
					state_n = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		rd_en    = (state_q == BK_READ);
		rd_addr  = head.cmd.bank ? AW'(MAX_LINE) + AW'(idx_q) : AW'(idx_q);
		m_tvalid = (state_q == BK_SEND) || (state_q == BK_NEWLINE);
		m_tdata  = (state_q == BK_NEWLINE) ? NEWLINE_BYTE : rd_data;
		m_tlast  = (state_q == BK_NEWLINE);
		m_tuser  = head.cmd.trunc;
		pop      = (state_q == BK_NEWLINE) && m_tready;
	end

	// state and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_IDLE) begin
				idx_q <= '0;
			end else if ((state_q == BK_SEND) && m_tready) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// testbench of the fixed string line filter: directed rows, then random lines against a predictor
module tb;
	import flf_pkg::*;

	localparam int LINE_CAP      = 63;
	localparam int WIN_LEN       = 16;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 4000000;
	localparam int PHASE_ITEMS   = 70;
	localparam int PHASES        = 6;

	// one emitted byte as seen on the m_ stream
	typedef struct packed {
		logic [7:0] data;
		logic       line_end;
		logic       trunc;
	} out_req_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	// one directed row: a register write or a byte with optional fixed results
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic [7:0]            data;
		logic                  eoi;
		bit                    fixed;
		int                    n;
		out_req_t              o0;
		out_req_t              o1;
	} row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;   // text_byte
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;          // out_byte
	logic                  m_tlast;
	logic                  m_tuser;          // line_truncated

	fixed_string_line_filter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// pattern registers as the block should hold them
	logic [63:0]          pat_low  = '0;
	logic [63:0]          pat_high = '0;
	logic [PAT_LEN_W-1:0] pat_len  = '0;

	// open line state of the predictor
	logic [7:0] line_store [LINE_CAP];
	int         line_fill = 0;
	bit         line_over = 1'b0;
	logic [7:0] match_win [WIN_LEN];
	int         win_fill  = 0;
	bit         line_hit  = 1'b0;

	out_req_t   fresh_out [$];
	out_req_t   line_out_q [$];
	row_t       dir_rows [$];
	out_req_t   got;
	out_req_t   want;

	int          mismatches  = 0;
	int          items_sent  = 0;
	int          stall_left  = 0;
	int unsigned cycle_count = 0;
	bit          idle_on     = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] pat_byte(int i);
		return (i < 8) ? pat_low[8*i +: 8] : pat_high[8*(i-8) +: 8];
	endfunction

	function automatic int active_len();
		return (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
	endfunction

	// predict the lines emitted for one accepted text byte
	task automatic filter_byte(input logic [7:0] b, input logic eoi);
		int plen;
		bit hit;
		fresh_out.delete();
		plen = active_len();
		if (b != NEWLINE_BYTE) begin
			if (line_fill < LINE_CAP) begin
				line_store[line_fill] = b;
				line_fill++;
			end else begin
				line_over = 1'b1;
			end
			for (int k = 0; k < WIN_LEN - 1; k++)
				match_win[k] = match_win[k+1];
			match_win[WIN_LEN-1] = b;
			if (win_fill < WIN_LEN)
				win_fill++;
			if (plen != 0 && win_fill >= plen) begin
				hit = 1'b1;
				for (int i = 0; i < plen; i++)
					if (match_win[WIN_LEN-plen+i] != pat_byte(i))
						hit = 1'b0;
				if (hit)
					line_hit = 1'b1;
			end
		end
		// close the line on newline or end of input
		if (b == NEWLINE_BYTE || eoi) begin
			if (line_hit || plen == 0) begin
				for (int i = 0; i < line_fill; i++)
					fresh_out.push_back('{line_store[i], 1'b0, line_over});
				fresh_out.push_back('{NEWLINE_BYTE, 1'b1, line_over});
			end
			line_fill = 0;
			line_over = 1'b0;
			win_fill  = 0;
			line_hit  = 1'b0;
		end
	endtask

	// present one request and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		do @(posedge clk); while (!s_tready);
		filter_byte(b, eoi);
	endtask

	task automatic feed(input logic [7:0] b, input logic eoi);
		send_byte(b, eoi);
		foreach (fresh_out[i])
			line_out_q.push_back(fresh_out[i]);
		items_sent++;
	endtask

	// stop intake and let every pending line drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (line_out_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PAT_LOW:  pat_low  = val;
			REG_PAT_HIGH: pat_high = val;
			REG_PAT_LEN:  pat_len  = val[PAT_LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		row_t r;
		r = '{ROW_CFG, idx, val, 8'h00, 1'b0, 1'b0, 0, '0, '0};
		dir_rows.push_back(r);
	endtask

	task automatic row_send(input logic [7:0] b, input logic eoi);
		row_t r;
		r = '{ROW_BYTE, REG_PAT_LOW, '0, b, eoi, 1'b0, 0, '0, '0};
		dir_rows.push_back(r);
	endtask

	task automatic row_fixed(input logic [7:0] b, input logic eoi, input int n,
			input out_req_t o0, input out_req_t o1);
		row_t r;
		r = '{ROW_BYTE, REG_PAT_LOW, '0, b, eoi, 1'b1, n, o0, o1};
		dir_rows.push_back(r);
	endtask

	// one random line, mostly built around the pattern, closed by newline or end of input
	task automatic send_line();
		logic [7:0] text [$];
		logic [7:0] b;
		int         len;
		int         plen;
		int         spot;
		int         ending;
		plen = active_len();
		len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 12);
		for (int i = 0; i < len; i++) begin
			spot = $urandom_range(0, 19);
			if (spot == 0) begin
				b = 8'($urandom_range(0, 255));
			end else if (spot < 10 && plen > 0) begin
				b = pat_byte($urandom_range(0, plen - 1));
			end else begin
				b = 8'($urandom_range(0, 255));
				if (b == NEWLINE_BYTE)
					b = 8'h0b;
			end
			text.push_back(b);
		end
		if (plen > 0 && $urandom_range(0, 2) != 0) begin
			spot = $urandom_range(0, text.size());
			for (int i = 0; i < plen; i++)
				text.insert(spot + i, pat_byte(i));
		end
		ending = (text.size() > 0) ? $urandom_range(0, 7) : $urandom_range(1, 7);
		foreach (text[i])
			feed(text[i], ending == 0 && i == text.size() - 1);
		if (ending != 0)
			feed(NEWLINE_BYTE, ending == 1);
	endtask

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 9) - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each taken output request with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata, m_tlast, m_tuser};
			if (line_out_q.size() == 0) begin
				$display("%0t: unexpected request byte %h end %b trunc %b",
					$time, got.data, got.line_end, got.trunc);
				mismatches++;
			end else begin
				want = line_out_q.pop_front();
				if (got !== want) begin
					$display("%0t: expected byte %h end %b trunc %b, got byte %h end %b trunc %b",
						$time, want.data, want.line_end, want.trunc,
						got.data, got.line_end, got.trunc);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [127:0] pat_vec;
		logic [7:0]   nb;
		int           new_len;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// empty pattern after reset: every line, empty ones too
		row_fixed(NEWLINE_BYTE, 1'b0, 1, '{NEWLINE_BYTE, 1'b1, 1'b0}, '0);
		row_fixed(8'h00, 1'b1, 2, '{8'h00, 1'b0, 1'b0}, '{NEWLINE_BYTE, 1'b1, 1'b0});
		row_fixed(8'hff, 1'b0, 0, '0, '0);
		row_fixed(NEWLINE_BYTE, 1'b1, 2, '{8'hff, 1'b0, 1'b0}, '{NEWLINE_BYTE, 1'b1, 1'b0});
		// two byte pattern
		row_cfg(REG_PAT_LOW, 64'h6261);
		row_cfg(REG_PAT_LEN, 64'd2);
		row_fixed("x", 1'b0, 0, '0, '0);
		row_fixed("a", 1'b0, 0, '0, '0);
		row_fixed("b", 1'b0, 0, '0, '0);
		row_send(NEWLINE_BYTE, 1'b0);
		row_fixed(NEWLINE_BYTE, 1'b0, 0, '0, '0);
		row_fixed("a", 1'b1, 0, '0, '0);
		row_send("b", 1'b0);
		row_send("a", 1'b0);
		row_send("b", 1'b1);
		// pattern changed while a matched line is open
		row_cfg(REG_PAT_LEN, 64'd1);
		row_cfg(REG_PAT_LOW, 64'h71);
		row_fixed("q", 1'b0, 0, '0, '0);
		row_cfg(REG_PAT_LOW, 64'h7a);
		row_send("c", 1'b1);
		row_fixed("q", 1'b1, 0, '0, '0);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				settle();
				write_reg(dir_rows[r].idx, dir_rows[r].val);
			end else begin
				send_byte(dir_rows[r].data, dir_rows[r].eoi);
				if (dir_rows[r].fixed) begin
					if (dir_rows[r].n > 0)
						line_out_q.push_back(dir_rows[r].o0);
					if (dir_rows[r].n > 1)
						line_out_q.push_back(dir_rows[r].o1);
				end else begin
					foreach (fresh_out[i])
						line_out_q.push_back(fresh_out[i]);
				end
			end
		end

		// random lines under several pattern settings, the last without idling
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			idle_on = (ph != PHASES - 1);
			for (int i = 0; i < PAT_BYTES; i++) begin
				do nb = 8'($urandom_range(0, 255)); while (nb == NEWLINE_BYTE);
				pat_vec[8*i +: 8] = nb;
			end
			case (ph)
				0: new_len = 0;
				1: new_len = 1;
				2: begin
					pat_vec = '1;
					new_len = PAT_BYTES;
				end
				3: begin
					pat_vec = '0;
					new_len = 5;
				end
				4: new_len = $urandom_range(PAT_BYTES + 1, 31);
				default: new_len = $urandom_range(2, 8);
			endcase
			write_reg(REG_PAT_LOW, pat_vec[63:0]);
			write_reg(REG_PAT_HIGH, pat_vec[127:64]);
			write_reg(REG_PAT_LEN, CFG_DATA_W'(new_len));
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				send_line();
		end

		settle();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
